// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion, quiet while reset is held
`define LAGE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent assertion, also checked through reset
`define LAGE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/lage_pkg.sv
package lage_pkg;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 9;
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DIM_W      = 10;
  localparam int BRIGHT_W   = 8;
  localparam int POP_W      = 19;
  localparam int CELL_TOTAL = 1 << ADDR_W;
  localparam logic [DIM_W-1:0]    MAX_COLS   = DIM_W'(1 << COL_W);
  localparam logic [DIM_W-1:0]    MAX_ROWS   = DIM_W'(1 << ROW_W);
  localparam logic [BRIGHT_W-1:0] RISE_STEP  = 8'd38;
  localparam logic [BRIGHT_W-1:0] FALL_STEP  = 8'd13;
  localparam logic [BRIGHT_W-1:0] FULL_BRIGHT = 8'd255;
  localparam logic [POP_W-1:0]    POP_LIMIT  = {POP_W{1'b1}};

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_COPY
  } state_t;

  typedef struct packed {
    mode_t            mode;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             cell_value;
  } in_req_t;

  typedef struct packed {
    logic                cell_alive;
    logic [BRIGHT_W-1:0] cell_brightness;
    logic [POP_W-1:0]    population;
  } out_res_t;
endpackage

// File: hw/rtl/lage_rule.sv
// B3/S23 on a 3x3 window; columns of three bits {bottom, middle, top}, oldest lowest
module lage_rule (
  input  logic [8:0] win,
  output logic       alive_nxt
);
  logic [3:0] count;

  assign count = 4'(win[0]) + 4'(win[1]) + 4'(win[2]) + 4'(win[3])
               + 4'(win[5]) + 4'(win[6]) + 4'(win[7]) + 4'(win[8]);
  assign alive_nxt = (count == 4'd3) || (win[4] && count == 4'd2);
endmodule

// File: hw/rtl/life_automaton_grid_engine_top.sv
// channel | direction | handshake          | payload
// in_     | in        | in_valid/in_stall  | lage_pkg::in_req_t
// out_    | out       | out_valid/out_stall| lage_pkg::out_res_t
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
// After reset a clearing pass writes every cell before requests are taken.
// Write and unused mode give their result straight from IDLE; read goes through READ (one memory read).
// Advance: a neighbour pass in FETCH (three reads of the single cell memory port per column)
// then a swap and fade pass in COPY.
// One request at a time; the result register lets the next request in while taken.
module life_automaton_grid_engine_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lage_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lage_pkg::out_res_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [lage_pkg::DIM_W-1:0] cfg_data
);
  localparam int CW = lage_pkg::COL_W;
  localparam int RW = lage_pkg::ROW_W;
  localparam int AW = lage_pkg::ADDR_W;
  localparam int BW = lage_pkg::BRIGHT_W;
  localparam int PW = lage_pkg::POP_W;

  logic                live_mem   [lage_pkg::CELL_TOTAL];
  logic                nxt_mem    [lage_pkg::CELL_TOTAL];
  logic [BW-1:0]       bright_mem [lage_pkg::CELL_TOTAL];

  lage_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r;
  logic [lage_pkg::DIM_W-1:0] w_r, h_r, cfg_clamp, cfg_max;
  logic [CW-1:0]       wl;
  logic [RW-1:0]       hl;

  logic [RW-1:0]       row_r, row_up, row_dn, row_sel;
  logic [CW-1:0]       fc_r, cc_r;
  logic [1:0]          sub_r, pre_r;
  logic [1:0]          colbuf_r;
  logic [8:0]          win_r, win_nxt;
  logic                rule_alive;

  logic [RW-1:0]       p2_row_r;
  logic [CW-1:0]       p2_col_r;
  logic                p2_run_r, p2v_r;
  logic [AW-1:0]       p2_addr_r;
  logic [PW-1:0]       pop_r, pop_inc, pop_final;

  logic                rd_inside_r;
  lage_pkg::out_res_t  out_r;
  logic                out_valid_r;

  logic                accept, out_free, cell_inside, cell_done;
  logic                fetch_last, copy_end;

  logic                live_we, live_wdata, live_rdata;
  logic [AW-1:0]       live_waddr, live_raddr;
  logic                nxt_we, nxt_wdata, nxt_rdata;
  logic [AW-1:0]       nxt_waddr;
  logic                bright_we;
  logic [BW-1:0]       bright_wdata, bright_rdata;
  logic [AW-1:0]       bright_waddr, bright_raddr;
  logic [BW:0]         bright_up;

  assign wl = CW'(w_r - 1'b1);
  assign hl = RW'(h_r - 1'b1);
  assign row_up = (row_r == '0) ? hl : row_r - 1'b1;
  assign row_dn = (row_r == hl) ? '0 : row_r + 1'b1;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == lage_pkg::ST_IDLE && out_free);
  assign accept   = in_valid && !in_stall;
  assign cell_inside = ({1'b0, in_data.col} < w_r) && ({1'b0, in_data.row} < h_r);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cfg_max   = (cfg_index == lage_pkg::CFG_HEIGHT) ? lage_pkg::MAX_ROWS :
                     lage_pkg::MAX_COLS;
  assign cfg_clamp = (cfg_data == '0) ? lage_pkg::DIM_W'(1) :
                     (cfg_data > cfg_max) ? cfg_max : cfg_data;

  // a cell is finished at the last read slot once two columns are already held
  assign cell_done  = (state_r == lage_pkg::ST_FETCH) && (sub_r == 2'd3) && (pre_r == 2'd2);
  assign fetch_last = cell_done && (cc_r == wl) && (row_r == hl);
  assign copy_end   = (state_r == lage_pkg::ST_COPY) && !p2_run_r && p2v_r;

  assign win_nxt = {live_rdata, colbuf_r, win_r[8:3]};

  lage_rule u_rule (
    .win       (win_nxt),
    .alive_nxt (rule_alive)
  );

  assign bright_up = {1'b0, bright_rdata} + {1'b0, lage_pkg::RISE_STEP};
  assign pop_inc   = (pop_r == lage_pkg::POP_LIMIT) ? pop_r : pop_r + 1'b1;
  assign pop_final = nxt_rdata ? pop_inc : pop_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lage_pkg::ST_CLEAR: begin
        if (clr_cnt_r == {AW{1'b1}}) state_nxt = lage_pkg::ST_IDLE;
      end
      lage_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.mode == lage_pkg::MODE_READ) state_nxt = lage_pkg::ST_READ;
          else if (in_data.mode == lage_pkg::MODE_ADVANCE) state_nxt = lage_pkg::ST_FETCH;
        end
      end
      lage_pkg::ST_READ:  state_nxt = lage_pkg::ST_IDLE;
      lage_pkg::ST_FETCH: begin
        if (fetch_last) state_nxt = lage_pkg::ST_COPY;
      end
      lage_pkg::ST_COPY: begin
        if (copy_end) state_nxt = lage_pkg::ST_IDLE;
      end
      default: state_nxt = lage_pkg::ST_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    unique case (sub_r)
      2'd0:    row_sel = row_up;
      2'd1:    row_sel = row_r;
      default: row_sel = row_dn;
    endcase
    live_we      = 1'b0;
    live_waddr   = {in_data.row, in_data.col};
    live_wdata   = in_data.cell_value;
    live_raddr   = {in_data.row, in_data.col};
    nxt_we       = cell_done;
    nxt_waddr    = {row_r, cc_r};
    nxt_wdata    = rule_alive;
    bright_we    = 1'b0;
    bright_waddr = p2_addr_r;
    bright_wdata = '0;
    bright_raddr = {in_data.row, in_data.col};
    unique case (state_r)
      lage_pkg::ST_CLEAR: begin
        live_we      = 1'b1;
        live_waddr   = clr_cnt_r;
        live_wdata   = 1'b0;
        bright_we    = 1'b1;
        bright_waddr = clr_cnt_r;
      end
      lage_pkg::ST_IDLE: begin
        live_we = accept && (in_data.mode == lage_pkg::MODE_WRITE) && cell_inside;
      end
      lage_pkg::ST_FETCH: begin
        live_raddr = {row_sel, fc_r};
      end
      lage_pkg::ST_COPY: begin
        live_we      = p2v_r;
        live_waddr   = p2_addr_r;
        live_wdata   = nxt_rdata;
        bright_we    = p2v_r;
        bright_raddr = {p2_row_r, p2_col_r};
        if (nxt_rdata) begin
          bright_wdata = bright_up[BW] ? lage_pkg::FULL_BRIGHT : bright_up[BW-1:0];
        end else begin
          bright_wdata = (bright_rdata > lage_pkg::FALL_STEP) ?
                         bright_rdata - lage_pkg::FALL_STEP : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (live_we) live_mem[live_waddr] <= live_wdata;
    live_rdata <= live_mem[live_raddr];
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    nxt_rdata <= nxt_mem[{p2_row_r, p2_col_r}];
    if (bright_we) bright_mem[bright_waddr] <= bright_wdata;
    bright_rdata <= bright_mem[bright_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lage_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      w_r         <= lage_pkg::MAX_COLS;
      h_r         <= lage_pkg::MAX_ROWS;
      out_valid_r <= 1'b0;
      p2_run_r    <= 1'b0;
      p2v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lage_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lage_pkg::CFG_WIDTH) w_r <= cfg_clamp;
        if (cfg_index == lage_pkg::CFG_HEIGHT) h_r <= cfg_clamp;
      end
      if (fetch_last) begin
        p2_run_r <= 1'b1;
      end else if (state_r == lage_pkg::ST_COPY && p2_run_r &&
                   p2_col_r == wl && p2_row_r == hl) begin
        p2_run_r <= 1'b0;
      end
      p2v_r <= (state_r == lage_pkg::ST_COPY) && p2_run_r;
      if ((accept && in_data.mode != lage_pkg::MODE_READ &&
           in_data.mode != lage_pkg::MODE_ADVANCE) ||
          state_r == lage_pkg::ST_READ || copy_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) rd_inside_r <= cell_inside;

    if (accept) begin
      out_r <= '0;
    end else if (state_r == lage_pkg::ST_READ) begin
      out_r.cell_alive      <= rd_inside_r & live_rdata;
      out_r.cell_brightness <= rd_inside_r ? bright_rdata : '0;
      out_r.population      <= '0;
    end else if (copy_end) begin
      out_r.cell_alive      <= 1'b0;
      out_r.cell_brightness <= '0;
      out_r.population      <= pop_final;
    end

    if (accept && in_data.mode == lage_pkg::MODE_ADVANCE) begin
      row_r <= '0;
      fc_r  <= wl;
      cc_r  <= '0;
      sub_r <= '0;
      pre_r <= '0;
    end else if (state_r == lage_pkg::ST_FETCH) begin
      sub_r <= sub_r + 1'b1;
      if (sub_r == 2'd1) colbuf_r[0] <= live_rdata;
      if (sub_r == 2'd2) colbuf_r[1] <= live_rdata;
      if (sub_r == 2'd3) begin
        win_r <= win_nxt;
        fc_r  <= (fc_r == wl) ? '0 : fc_r + 1'b1;
        if (pre_r != 2'd2) begin
          pre_r <= pre_r + 1'b1;
        end else if (cc_r == wl) begin
          // row finished: restart the window at the wrapped left column
          cc_r  <= '0;
          pre_r <= '0;
          fc_r  <= wl;
          row_r <= row_r + 1'b1;
        end else begin
          cc_r <= cc_r + 1'b1;
        end
      end
    end

    if (fetch_last) begin
      p2_row_r <= '0;
      p2_col_r <= '0;
      pop_r    <= '0;
    end else if (state_r == lage_pkg::ST_COPY) begin
      if (p2_run_r) begin
        p2_addr_r <= {p2_row_r, p2_col_r};
        if (p2_col_r == wl) begin
          p2_col_r <= '0;
          p2_row_r <= p2_row_r + 1'b1;
        end else begin
          p2_col_r <= p2_col_r + 1'b1;
        end
      end
      if (p2v_r) pop_r <= pop_final;
    end
  end
endmodule

// File: hw/rtl/lage_checker.sv
`include "assert_macros.svh"
module lage_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input lage_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input lage_pkg::out_res_t out_data
);
  `LAGE_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `LAGE_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
  `LAGE_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result shown after reset")
  `LAGE_ASSERT(a_write_done, clk, rst_n, in_valid && !in_stall && in_data.mode == lage_pkg::MODE_WRITE |=> out_valid && out_data.population == '0, "write request gave no result")
endmodule

bind life_automaton_grid_engine_top lage_checker u_lage_checker (.*);

// File: tb/life_automaton_grid_engine_checker.sv
`timescale 1ns / 1ps

module life_automaton_grid_engine_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  lage_pkg::in_req_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  lage_pkg::out_res_t         out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [lage_pkg::DIM_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         n_results,
  output int                         n_advances
);
  import lage_pkg::*;

  bit                grid[CELL_TOTAL];
  bit                grid_next[CELL_TOTAL];
  bit [BRIGHT_W-1:0] glow[CELL_TOTAL];
  logic [DIM_W-1:0]  cols_reg;
  logic [DIM_W-1:0]  rows_reg;
  out_res_t          results_due[$];

  initial begin
    errors     = 0;
    pending    = 0;
    n_results  = 0;
    n_advances = 0;
    cols_reg   = MAX_COLS;
    rows_reg   = MAX_ROWS;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic logic [POP_W-1:0] step_generation();
    int unsigned w, h, cnt, pop, idx, ri, ci, b;
    int unsigned rs[3];
    int unsigned cs[3];
    bit old;
    w = eff_dim(cols_reg, MAX_COLS);
    h = eff_dim(rows_reg, MAX_ROWS);
    pop = 0;
    for (int unsigned r = 0; r < h; r++) begin
      rs[0] = (r + h - 1) % h;
      rs[1] = r;
      rs[2] = (r + 1) % h;
      for (int unsigned c = 0; c < w; c++) begin
        cs[0] = (c + w - 1) % w;
        cs[1] = c;
        cs[2] = (c + 1) % w;
        cnt = 0;
        // wrapped neighbours on tiny grids are counted each time they appear
        for (ri = 0; ri < 3; ri++)
          for (ci = 0; ci < 3; ci++)
            if (ri != 1 || ci != 1) cnt += grid[rs[ri] * MAX_COLS + cs[ci]];
        idx = r * MAX_COLS + c;
        grid_next[idx] = grid[idx] ? (cnt == 2 || cnt == 3) : (cnt == 3);
      end
    end
    for (int unsigned r = 0; r < h; r++)
      for (int unsigned c = 0; c < w; c++) begin
        idx = r * MAX_COLS + c;
        old = grid[idx];
        grid[idx] = grid_next[idx];
        grid_next[idx] = old;
        b = glow[idx];
        if (grid[idx]) begin
          b = (b + RISE_STEP > FULL_BRIGHT) ? FULL_BRIGHT : b + RISE_STEP;
          if (pop < POP_LIMIT) pop++;
        end else begin
          b = (b > FALL_STEP) ? b - FALL_STEP : 0;
        end
        glow[idx] = b[BRIGHT_W-1:0];
      end
    return pop[POP_W-1:0];
  endfunction

  function automatic out_res_t predict_result(in_req_t q);
    out_res_t    res;
    int unsigned idx;
    bit          in_grid;
    res = '0;
    in_grid = (q.col < eff_dim(cols_reg, MAX_COLS)) && (q.row < eff_dim(rows_reg, MAX_ROWS));
    idx = q.row * MAX_COLS + q.col;
    case (q.mode)
      MODE_WRITE: begin
        if (in_grid) grid[idx] = q.cell_value;
      end
      MODE_READ: begin
        if (in_grid) begin
          res.cell_alive      = grid[idx];
          res.cell_brightness = glow[idx];
        end
      end
      MODE_ADVANCE: begin
        res.population = step_generation();
        n_advances++;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cols_reg <= MAX_COLS;
      rows_reg <= MAX_ROWS;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) cols_reg <= cfg_data;
        else rows_reg <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result alive=%0d bright=%0d pop=%0d", $time,
                   out_data.cell_alive, out_data.cell_brightness, out_data.population);
        end else begin
          out_res_t want;
          want = results_due.pop_front();
          if (out_data.cell_alive !== want.cell_alive) begin
            errors++;
            $display("%0t: cell_alive expected %0d got %0d", $time,
                     want.cell_alive, out_data.cell_alive);
          end
          if (out_data.cell_brightness !== want.cell_brightness) begin
            errors++;
            $display("%0t: cell_brightness expected %0d got %0d", $time,
                     want.cell_brightness, out_data.cell_brightness);
          end
          if (out_data.population !== want.population) begin
            errors++;
            $display("%0t: population expected %0d got %0d", $time,
                     want.population, out_data.population);
          end
        end
      end
      if (in_valid && !in_stall) results_due.push_back(predict_result(in_data));
      pending <= results_due.size();
    end
  end
endmodule

// File: tb/life_automaton_grid_engine_top_test.sv
`timescale 1ns / 1ps

module life_automaton_grid_engine_top_test;
  import lage_pkg::*;

  localparam int IDLE_LIMIT = 1500000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_req_t          in_data;
  logic             out_valid;
  logic             out_stall;
  out_res_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [DIM_W-1:0] cfg_data;

  int errors, pending, n_results, n_advances;
  int idle_cycles;
  int cols_eff, rows_eff;
  int n_sent;
  bit hold_req, hold_done;
  int hold_left, pat_cnt, pat_sel;

  life_automaton_grid_engine_top dut (.*);

  life_automaton_grid_engine_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending, .n_results, .n_advances
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // receiver: own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      pat_cnt   <= 0;
      pat_sel   <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      pat_cnt <= pat_cnt + 1;
      if (pat_cnt % 50 == 0) pat_sel <= $urandom_range(2);
      case (pat_sel)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        default: out_stall <= ($urandom_range(3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAIL life_automaton_grid_engine_top");
      $finish;
    end
  end

  function automatic in_req_t mk_req(mode_t m, int c, int r, bit v);
    in_req_t q;
    q.mode       = m;
    q.col        = c[COL_W-1:0];
    q.row        = r[ROW_W-1:0];
    q.cell_value = v;
    return q;
  endfunction

  task automatic send_req(in_req_t q);
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (in_stall);
    n_sent++;
    // bursts with random gaps between them
    if ($urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [DIM_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cols_eff = (w == 0) ? 1 : (w > MAX_COLS) ? MAX_COLS : w;
    rows_eff = (h == 0) ? 1 : (h > MAX_ROWS) ? MAX_ROWS : h;
  endtask

  task automatic rand_phase(int n, bit with_hold);
    int p;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == 5) hold_req <= 1'b1;
      p = $urandom_range(99);
      if (p < 10)
        send_req(mk_req(MODE_ADVANCE, $urandom_range(511), $urandom_range(511), $urandom_range(1)));
      else if (p < 55)
        send_req(mk_req(MODE_WRITE, $urandom_range(cols_eff - 1), $urandom_range(rows_eff - 1),
                        $urandom_range(1)));
      else if (p < 88)
        send_req(mk_req(MODE_READ, $urandom_range(cols_eff - 1), $urandom_range(rows_eff - 1), 0));
      else
        send_req(mk_req(mode_t'($urandom_range(3)), $urandom_range(511), $urandom_range(511),
                        $urandom_range(1)));
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= '0;
    hold_req  <= 1'b0;
    hold_done  = 1'b0;
    idle_cycles = 0;
    n_sent = 0;
    cols_eff = MAX_COLS;
    rows_eff = MAX_ROWS;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // full-size grid: corners, unused mode, nothing advanced at this size
    send_req(mk_req(MODE_WRITE, 511, 511, 1));
    send_req(mk_req(MODE_WRITE, 0, 0, 1));
    send_req(mk_req(MODE_READ, 511, 511, 0));
    send_req(mk_req(MODE_READ, 0, 0, 0));
    send_req(mk_req(MODE_READ, 300, 17, 0));
    send_req(mk_req(MODE_NONE, 511, 511, 1));
    send_req(mk_req(MODE_WRITE, 0, 0, 0));

    // glider on a 6x6 torus
    set_size(6, 6);
    send_req(mk_req(MODE_WRITE, 1, 0, 1));
    send_req(mk_req(MODE_WRITE, 2, 1, 1));
    send_req(mk_req(MODE_WRITE, 0, 2, 1));
    send_req(mk_req(MODE_WRITE, 1, 2, 1));
    send_req(mk_req(MODE_WRITE, 2, 2, 1));
    send_req(mk_req(MODE_WRITE, 6, 0, 1));   // outside: ignored
    send_req(mk_req(MODE_READ, 511, 511, 0)); // outside: zeros
    repeat (4) send_req(mk_req(MODE_ADVANCE, 0, 0, 0));
    send_req(mk_req(MODE_READ, 2, 3, 0));

    // glider carried over onto a 5x5 torus and advanced further
    set_size(5, 5);
    repeat (8) send_req(mk_req(MODE_ADVANCE, 0, 0, 0));
    send_req(mk_req(MODE_READ, 2, 3, 0));

    // size out of range and tiny grids
    set_size(0, 1023);
    send_req(mk_req(MODE_WRITE, 0, 7, 1));
    send_req(mk_req(MODE_ADVANCE, 0, 0, 0));
    set_size(1023, 2);
    send_req(mk_req(MODE_WRITE, 511, 1, 1));
    send_req(mk_req(MODE_ADVANCE, 0, 0, 0));
    set_size(2, 1);
    send_req(mk_req(MODE_WRITE, 1, 0, 1));
    send_req(mk_req(MODE_ADVANCE, 0, 0, 0));
    send_req(mk_req(MODE_READ, 0, 0, 0));
    set_size(1, 1);
    send_req(mk_req(MODE_WRITE, 0, 0, 1));
    send_req(mk_req(MODE_ADVANCE, 0, 0, 0));

    // random phases on small grids and one full-width strip, one with the long receiver hold-off
    set_size($urandom_range(3, 16), $urandom_range(3, 16));
    rand_phase(15, 1'b0);
    set_size($urandom_range(1, 24), $urandom_range(1, 24));
    rand_phase(20, 1'b1);
    set_size(512, $urandom_range(1, 3));
    rand_phase(15, 1'b0);
    set_size($urandom_range(1, 24), $urandom_range(1, 24));
    rand_phase(15, 1'b0);

    drain();
    repeat (50) @(posedge clk);
    if (pending != 0)
      $display("%0t: %0d results never arrived", $time, pending);
    $display("sent %0d requests, checked %0d results, %0d generations over several grid sizes",
             n_sent, n_results, n_advances);
    if (errors == 0 && pending == 0)
      $display("PASS life_automaton_grid_engine_top");
    else
      $display("FAIL life_automaton_grid_engine_top");
    $finish;
  end
endmodule
